@@ rtl/core/nbc_pkg.sv @@
// Shared constants, codes and word types of the NAND boot copy block.
package nbc_pkg;

    localparam int PAGE_BYTES      = 2048;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int ROW_BITS        = 24;

    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int BLOCK_BITS = $clog2(PAGES_PER_BLOCK);
    localparam int ROW_W      = 24;               // three row address bytes
    localparam int LP_W       = ROW_W;            // logical page counter
    localparam int PHYS_W     = LP_W + 1;         // page sums before the row check
    localparam int BC_W       = PAGE_BITS + 1;    // byte count reaches PAGE_BYTES
    localparam int SRC_PAGE_W = 32 - PAGE_BITS;

    localparam logic [PHYS_W-1:0] ROW_LIMIT = PHYS_W'(64'd1 << ROW_BITS);

    // NAND command and check bytes
    localparam logic [7:0] CMD_READ_ID  = 8'h90;
    localparam logic [7:0] CMD_READ     = 8'h00;
    localparam logic [7:0] CMD_READ_GO  = 8'h30;
    localparam logic [7:0] ID_ADDR      = 8'h00;
    localparam logic [7:0] ID_MIN       = 8'h80;
    localparam logic [7:0] SPARE_GOOD   = 8'hFF;
    localparam logic [7:0] SPARE_COL_LO = 8'(PAGE_BYTES & 255);
    localparam logic [7:0] SPARE_COL_HI = 8'((PAGE_BYTES >> 8) & 255);

    // input event codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_READY = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_OFFSET = 2'd0;
    localparam logic [1:0] CFG_COPY_BYTES    = 2'd1;
    localparam logic [1:0] CFG_DEST_BASE     = 2'd2;

    localparam logic [31:0] RST_SOURCE_OFFSET = 32'd0;
    localparam logic [31:0] RST_COPY_BYTES    = 32'd524288;
    localparam logic [31:0] RST_DEST_BASE     = 32'd870318080;

    // queue sizes
    localparam int JQ_DEPTH = 4;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam int TAIL_IDX_W = 3;

    typedef enum logic [2:0] {
        OP_CE_ON,
        OP_CE_OFF,
        OP_CMD,
        OP_ADDR,
        OP_STROBE,
        OP_MEMWR,
        OP_DONE,
        OP_ERROR
    } op_t;

    // closing sequence of a job
    typedef enum logic [2:0] {
        TAIL_ID,
        TAIL_STROBE,
        TAIL_DONE,
        TAIL_ERROR,
        TAIL_READ
    } tail_t;

    // one classified event: optional mem write, optional CE off, then the tail
    typedef struct packed {
        logic             memwr;
        logic             ce_off;
        tail_t            tail;
        logic [7:0]       data;
        logic [31:0]      addr;
        logic             spare;
        logic [ROW_W-1:0] row;
    } job_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  value;
        logic [31:0] addr;
        logic        wait_ready;
        logic        last;
    } result_t;

    function automatic logic [TAIL_IDX_W-1:0] tail_last_idx(tail_t t);
        logic [TAIL_IDX_W-1:0] n;
        case (t)
            TAIL_ID:   n = TAIL_IDX_W'(3);
            TAIL_READ: n = TAIL_IDX_W'(7);
            default:   n = '0;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/core/nand_boot_copy_bad_block_skip.sv @@
// Top level of the NAND boot copy sequencer with bad-block skipping.
// Usage:
//   Input events go in through a queue-style port: req_type/data_byte are
//   taken at a clock edge with push high and full low (start, NAND ready,
//   or a returned data byte). Each event yields zero to ten bus words
//   (CE, command, address, read strobe, mem write, done, error) on the
//   result port, oldest first, shown while empty is low and taken with pop.
//   The last word of an event has last set; wait_ready marks the end of a
//   read setup after which a ready event is expected.
//   Configuration (source offset, copy size, destination base) is written
//   on cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
// Timing:
//   An event's job is registered in the job queue, and each of its words in
//   the result queue, before the word is visible. The word sequencer emits
//   one word per cycle while the result queue has room (a data byte mostly
//   yields 2 words). The classifier takes an event every cycle while the
//   4-entry job queue has room; a stalled reader fills the 4-word result
//   queue, then the job queue, and then full rises.
// Reset:
//   rst_n empties both queues, idles the copy and reloads the registers.
module nand_boot_copy_bad_block_skip (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // event input
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    // bus word output
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  bus_op,
    output logic [7:0]  bus_value,
    output logic [31:0] mem_address,
    output logic        wait_ready,
    output logic        last
);
    import nbc_pkg::*;

    logic     accept;
    logic     job_push, jq_full, jq_valid, job_pop;
    job_t     new_job, head_job;
    result_t  res;

    assign cfg_ready = 1'b1;
    assign full      = jq_full;
    assign accept    = push && !jq_full;

    // classifier: owns the copy state, turns each accepted event into at most one job
    nbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req_type  (req_type),
        .data_byte (data_byte),
        .job_push  (job_push),
        .job       (new_job)
    );

    nbc_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .full     (jq_full),
        .pop      (job_pop),
        .valid    (jq_valid),
        .head     (head_job)
    );

    // sequencer: one bus word per cycle into the result queue while it has room
    nbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (jq_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .head      (res)
    );

    assign bus_op      = 3'(res.op);
    assign bus_value   = res.value;
    assign mem_address = res.addr;
    assign wait_ready  = res.wait_ready;
    assign last        = res.last;

endmodule

@@ rtl/core/nbc_front.sv @@
// Event classifier: config registers, copy state and job generation.
module nbc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    input  logic           accept,
    input  logic [1:0]     req_type,
    input  logic [7:0]     data_byte,
    output logic           job_push,
    output nbc_pkg::job_t  job
);
    import nbc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ID1,
        PH_ID2,
        PH_SPARE_READY,
        PH_SPARE_B1,
        PH_SPARE_B2,
        PH_PAGE_READY,
        PH_PAGE_DATA
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LP_W-1:0]    logical_page_reg, logical_page_next;
    logic [LP_W-1:0]    skip_pages_reg, skip_pages_next;
    logic [PHYS_W-1:0]  end_page_reg, end_page_next;
    logic [BC_W-1:0]    byte_count_reg, byte_count_next;
    logic [31:0]        write_pointer_reg, write_pointer_next;
    logic [7:0]         first_spare_reg, first_spare_next;
    logic [31:0]        src_offset_reg, copy_bytes_reg, dest_base_reg;

    logic [SRC_PAGE_W-1:0] src_page, copy_pages;
    logic [PHYS_W-1:0]     phys_cur, phys_skip, end_init;
    logic [BC_W-1:0]       bc_inc;
    logic                  init;
    logic [LP_W-1:0]       np_lp, np_skip;
    logic [PHYS_W-1:0]     np_end, np_phys;
    logic                  np_done, np_err, np_spare, do_next;

    always_comb
    begin
        src_page   = src_offset_reg[31:PAGE_BITS];
        copy_pages = copy_bytes_reg[31:PAGE_BITS];
        phys_cur   = PHYS_W'(logical_page_reg) + PHYS_W'(skip_pages_reg);
        phys_skip  = phys_cur + PHYS_W'(PAGES_PER_BLOCK);
        bc_inc     = byte_count_reg + BC_W'(1);
        end_init   = PHYS_W'(LP_W'(src_page)) + PHYS_W'(copy_pages);

        // next-page decision, shared by the ID check and the page end
        init     = (phase_reg == PH_ID2);
        np_lp    = init ? LP_W'(src_page) : logical_page_reg + LP_W'(1);
        np_end   = init ? end_init : end_page_reg;
        np_skip  = init ? '0 : skip_pages_reg;
        np_phys  = PHYS_W'(np_lp) + PHYS_W'(np_skip);
        np_done  = (PHYS_W'(np_lp) >= np_end);
        np_err   = (np_phys >= ROW_LIMIT);
        np_spare = (np_lp[BLOCK_BITS-1:0] == '0) && (np_phys != '0);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        logical_page_next  = logical_page_reg;
        skip_pages_next    = skip_pages_reg;
        end_page_next      = end_page_reg;
        byte_count_next    = byte_count_reg;
        write_pointer_next = write_pointer_reg;
        first_spare_next   = first_spare_reg;
        job_push           = 1'b0;
        job                = '0;
        job.tail           = TAIL_STROBE;
        do_next            = 1'b0;

        if (accept)
        begin
            case (req_type)
                REQ_START:
                begin
                    job_push   = 1'b1;
                    job.tail   = TAIL_ID;
                    phase_next = PH_ID1;
                end
                REQ_READY:
                begin
                    if (phase_reg == PH_SPARE_READY)
                    begin
                        job_push   = 1'b1;
                        phase_next = PH_SPARE_B1;
                    end
                    else if (phase_reg == PH_PAGE_READY)
                    begin
                        job_push   = 1'b1;
                        phase_next = PH_PAGE_DATA;
                    end
                end
                REQ_DATA:
                begin
                    case (phase_reg)
                        PH_ID1:
                        begin
                            job_push   = 1'b1;
                            phase_next = PH_ID2;
                        end
                        PH_ID2:
                        begin
                            job_push = 1'b1;
                            if (data_byte <= ID_MIN)
                            begin
                                job.tail   = TAIL_ERROR;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                skip_pages_next    = '0;
                                end_page_next      = np_end;
                                write_pointer_next = dest_base_reg;
                                byte_count_next    = '0;
                                do_next            = 1'b1;
                            end
                        end
                        PH_SPARE_B1:
                        begin
                            job_push         = 1'b1;
                            first_spare_next = data_byte;
                            phase_next       = PH_SPARE_B2;
                        end
                        PH_SPARE_B2:
                        begin
                            job_push   = 1'b1;
                            job.ce_off = 1'b1;
                            if (first_spare_reg == SPARE_GOOD && data_byte == SPARE_GOOD)
                            begin
                                job.tail        = TAIL_READ;
                                job.row         = phys_cur[ROW_W-1:0];
                                byte_count_next = '0;
                                phase_next      = PH_PAGE_READY;
                            end
                            else if (phys_skip >= ROW_LIMIT)
                            begin
                                job.tail   = TAIL_ERROR;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                skip_pages_next = skip_pages_reg + LP_W'(PAGES_PER_BLOCK);
                                job.tail        = TAIL_READ;
                                job.spare       = 1'b1;
                                job.row         = phys_skip[ROW_W-1:0];
                                phase_next      = PH_SPARE_READY;
                            end
                        end
                        PH_PAGE_DATA:
                        begin
                            job_push           = 1'b1;
                            job.memwr          = 1'b1;
                            job.data           = data_byte;
                            job.addr           = write_pointer_reg;
                            write_pointer_next = write_pointer_reg + 32'd1;
                            byte_count_next    = bc_inc;
                            if (bc_inc >= BC_W'(PAGE_BYTES))
                            begin
                                job.ce_off = 1'b1;
                                do_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            if (do_next)
            begin
                logical_page_next = np_lp;
                if (np_done)
                begin
                    job.tail   = TAIL_DONE;
                    phase_next = PH_IDLE;
                end
                else if (np_err)
                begin
                    job.tail   = TAIL_ERROR;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    job.tail  = TAIL_READ;
                    job.spare = np_spare;
                    job.row   = np_phys[ROW_W-1:0];
                    if (np_spare)
                    begin
                        phase_next = PH_SPARE_READY;
                    end
                    else
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_PAGE_READY;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            logical_page_reg  <= '0;
            skip_pages_reg    <= '0;
            end_page_reg      <= '0;
            byte_count_reg    <= '0;
            write_pointer_reg <= '0;
            first_spare_reg   <= '0;
            src_offset_reg    <= RST_SOURCE_OFFSET;
            copy_bytes_reg    <= RST_COPY_BYTES;
            dest_base_reg     <= RST_DEST_BASE;
        end
        else
        begin
            phase_reg         <= phase_next;
            logical_page_reg  <= logical_page_next;
            skip_pages_reg    <= skip_pages_next;
            end_page_reg      <= end_page_next;
            byte_count_reg    <= byte_count_next;
            write_pointer_reg <= write_pointer_next;
            first_spare_reg   <= first_spare_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SOURCE_OFFSET: src_offset_reg <= cfg_data;
                    CFG_COPY_BYTES:    copy_bytes_reg <= cfg_data;
                    CFG_DEST_BASE:     dest_base_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    // a page never holds more than PAGE_BYTES data strobes
    a_page_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAGE_DATA |-> byte_count_reg < BC_W'(PAGE_BYTES))
        else $error("byte count overran page in data phase");

    // skips move in whole blocks only
    a_skip_block: assert property (@(posedge clk) disable iff (!rst_n)
        skip_pages_reg[BLOCK_BITS-1:0] == '0)
        else $error("skip count not block aligned");
`endif

endmodule

@@ rtl/core/nbc_job_queue.sv @@
// Short job queue between the classifier and the word sequencer.
module nbc_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nbc_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output nbc_pkg::job_t  head
);
    import nbc_pkg::*;

    job_t              mem_reg [JQ_DEPTH];
    logic [JQ_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [JQ_CW-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == JQ_CW'(JQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + JQ_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + JQ_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + JQ_CW'(1);
                2'b01:   count_reg <= count_reg - JQ_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/core/nbc_back.sv @@
// Word sequencer: expands each job into bus words and buffers them for the reader.
module nbc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  nbc_pkg::job_t     job,
    output logic              job_pop,
    input  logic              pop,
    output logic              empty,
    output nbc_pkg::result_t  head
);
    import nbc_pkg::*;

    logic                   memwr_done_reg, memwr_done_next;
    logic                   ceoff_done_reg, ceoff_done_next;
    logic [TAIL_IDX_W-1:0]  tail_idx_reg, tail_idx_next;

    result_t                rq_mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]       rq_wr_reg, rq_rd_reg;
    logic [RQ_CW-1:0]       rq_count_reg;

    logic     pend_memwr, pend_ce, tail_end, room, fire, rq_pop;
    result_t  word;

    assign pend_memwr = job.memwr && !memwr_done_reg;
    assign pend_ce    = job.ce_off && !ceoff_done_reg;
    assign tail_end   = !pend_memwr && !pend_ce && (tail_idx_reg == tail_last_idx(job.tail));
    assign room       = (rq_count_reg != RQ_CW'(RQ_DEPTH));
    assign fire       = job_valid && room;
    assign job_pop    = fire && tail_end;
    assign empty      = (rq_count_reg == '0);
    assign rq_pop     = pop && !empty;
    assign head       = rq_mem_reg[rq_rd_reg];

    always_comb
    begin
        word            = '0;
        word.op         = OP_STROBE;
        if (pend_memwr)
        begin
            word.op    = OP_MEMWR;
            word.value = job.data;
            word.addr  = job.addr;
        end
        else if (pend_ce)
        begin
            word.op = OP_CE_OFF;
        end
        else
        begin
            case (job.tail)
                TAIL_ID:
                begin
                    case (tail_idx_reg)
                        3'd0: word.op = OP_CE_ON;
                        3'd1:
                        begin
                            word.op    = OP_CMD;
                            word.value = CMD_READ_ID;
                        end
                        3'd2:
                        begin
                            word.op    = OP_ADDR;
                            word.value = ID_ADDR;
                        end
                        default: word.op = OP_STROBE;
                    endcase
                end
                TAIL_READ:
                begin
                    word.op = OP_ADDR;
                    case (tail_idx_reg)
                        3'd0: word.op = OP_CE_ON;
                        3'd1:
                        begin
                            word.op    = OP_CMD;
                            word.value = CMD_READ;
                        end
                        3'd2: word.value = job.spare ? SPARE_COL_LO : 8'h00;
                        3'd3: word.value = job.spare ? SPARE_COL_HI : 8'h00;
                        3'd4: word.value = job.row[7:0];
                        3'd5: word.value = job.row[15:8];
                        3'd6: word.value = job.row[23:16];
                        default:
                        begin
                            word.op    = OP_CMD;
                            word.value = CMD_READ_GO;
                        end
                    endcase
                end
                TAIL_DONE:  word.op = OP_DONE;
                TAIL_ERROR: word.op = OP_ERROR;
                default:    word.op = OP_STROBE;
            endcase
        end
        word.last       = tail_end;
        word.wait_ready = tail_end && (job.tail == TAIL_READ);
    end

    always_comb
    begin
        memwr_done_next = memwr_done_reg;
        ceoff_done_next = ceoff_done_reg;
        tail_idx_next   = tail_idx_reg;
        if (fire)
        begin
            if (tail_end)
            begin
                memwr_done_next = 1'b0;
                ceoff_done_next = 1'b0;
                tail_idx_next   = '0;
            end
            else if (pend_memwr)
            begin
                memwr_done_next = 1'b1;
            end
            else if (pend_ce)
            begin
                ceoff_done_next = 1'b1;
            end
            else
            begin
                tail_idx_next = tail_idx_reg + TAIL_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rq_mem_reg[rq_wr_reg] <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memwr_done_reg <= 1'b0;
            ceoff_done_reg <= 1'b0;
            tail_idx_reg   <= '0;
            rq_wr_reg      <= '0;
            rq_rd_reg      <= '0;
            rq_count_reg   <= '0;
        end
        else
        begin
            memwr_done_reg <= memwr_done_next;
            ceoff_done_reg <= ceoff_done_next;
            tail_idx_reg   <= tail_idx_next;
            if (fire)
            begin
                rq_wr_reg <= rq_wr_reg + RQ_AW'(1);
            end
            if (rq_pop)
            begin
                rq_rd_reg <= rq_rd_reg + RQ_AW'(1);
            end
            case ({fire, rq_pop})
                2'b10:   rq_count_reg <= rq_count_reg + RQ_CW'(1);
                2'b01:   rq_count_reg <= rq_count_reg - RQ_CW'(1);
                default: rq_count_reg <= rq_count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the word index never runs past the end of the current job's tail
    a_tail_idx: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> tail_idx_reg <= tail_last_idx(job.tail))
        else $error("tail index beyond job length");

    // progress marks are clear whenever no job is waiting
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid |-> (!memwr_done_reg && !ceoff_done_reg && tail_idx_reg == '0))
        else $error("sequencer progress left over without a job");

    // a word that asks for a ready wait always closes its job
    a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.wait_ready |-> job_pop && word.last)
        else $error("wait flag on a word that does not end the job");
`endif

endmodule
